### sv/bta_pkg.sv
// ----------------------------------------------------------------------------
// Block transfer address sequencer package
// Shared types, codes and constants for the block transfer address sequencer.
// ----------------------------------------------------------------------------
package bta_pkg;

  localparam int unsigned AddrW = 16;
  localparam int unsigned LenW  = 16;

  // Effective length used when a start transfer carries a length of zero.
  localparam logic [LenW-1:0] LenZeroSubst = 16'hFFFF;

  // Input tdata packing: mode, source, destination, length, zero padding.
  localparam int unsigned InFieldsW = 1 + AddrW + AddrW + LenW;
  localparam int unsigned InTdataW  = ((InFieldsW + 7) / 8) * 8;
  localparam int unsigned InPadW    = InTdataW - InFieldsW;

  // Output tdata packing: source, destination, total length.
  localparam int unsigned OutTdataW = AddrW + AddrW + LenW;

  // Item kind carried on the input tuser.
  typedef enum logic {
    ACT_START = 1'b0,
    ACT_STEP  = 1'b1
  } action_e;

  // Pointer movement pattern selected at start.
  typedef enum logic {
    MODE_ALT_SRC = 1'b0,
    MODE_ALT_DST = 1'b1
  } mode_e;

  // One input item.
  typedef struct packed {
    action_e          action;
    mode_e            mode;
    logic [AddrW-1:0] source_start;
    logic [AddrW-1:0] destination_start;
    logic [LenW-1:0]  length_start;
  } item_t;

  // One result item.
  typedef struct packed {
    logic             copy_valid;
    logic [AddrW-1:0] source_address;
    logic [AddrW-1:0] destination_address;
    logic             last;
    logic [LenW-1:0]  reported_length;
  } result_t;

  // Sequencer state carried from one item to the next.
  typedef struct packed {
    logic [AddrW-1:0] source_pointer;
    logic [AddrW-1:0] destination_pointer;
    logic [LenW-1:0]  remaining;
    logic             alternate_up;
    mode_e            mode_in_use;
  } seq_state_t;

endpackage

### sv/bta_step_logic.sv
// ----------------------------------------------------------------------------
// Block transfer step logic
// Computes the result of one item and the sequencer state that follows it.
// ----------------------------------------------------------------------------
module bta_step_logic (
  input  bta_pkg::item_t      item_i,
  input  bta_pkg::seq_state_t state_i,
  output bta_pkg::result_t    result_o,
  output bta_pkg::seq_state_t state_o
);

  logic [bta_pkg::LenW-1:0] eff_len;
  logic                     src_up;
  logic                     dst_up;

  // Zero length at start means the maximum count.
  assign eff_len = (item_i.length_start == '0) ? bta_pkg::LenZeroSubst
                                               : item_i.length_start;

  // The alternating pointer follows alternate_up, the other one always counts up.
  assign src_up = (state_i.mode_in_use == bta_pkg::MODE_ALT_SRC) ? state_i.alternate_up : 1'b1;
  assign dst_up = (state_i.mode_in_use == bta_pkg::MODE_ALT_DST) ? state_i.alternate_up : 1'b1;

  // Start loads the state, a step while busy names one copy and moves on.
  always_comb begin
    result_o = '0;
    state_o  = state_i;
    if (item_i.action == bta_pkg::ACT_START) begin
      state_o.source_pointer      = item_i.source_start;
      state_o.destination_pointer = item_i.destination_start;
      state_o.remaining           = eff_len;
      state_o.alternate_up        = 1'b1;
      state_o.mode_in_use         = item_i.mode;
      result_o.reported_length    = eff_len;
    end else if (state_i.remaining != '0) begin
      result_o.copy_valid          = 1'b1;
      result_o.source_address      = state_i.source_pointer;
      result_o.destination_address = state_i.destination_pointer;
      result_o.last                = (state_i.remaining == bta_pkg::LenW'(1));
      state_o.source_pointer       = src_up ? state_i.source_pointer + bta_pkg::AddrW'(1)
                                            : state_i.source_pointer - bta_pkg::AddrW'(1);
      state_o.destination_pointer  = dst_up ? state_i.destination_pointer + bta_pkg::AddrW'(1)
                                            : state_i.destination_pointer - bta_pkg::AddrW'(1);
      state_o.alternate_up         = ~state_i.alternate_up;
      state_o.remaining            = state_i.remaining - bta_pkg::LenW'(1);
    end
  end

endmodule

### sv/block_transfer_address_sequencer.sv
// ----------------------------------------------------------------------------
// Block transfer address sequencer
// Generates source and destination address pairs for block move instructions.
// ----------------------------------------------------------------------------
// Usage: each input transfer on the s_axis side is either a start (tuser 0),
// which loads source, destination, length and mode, or a step (tuser 1),
// which asks for the next byte copy. Every input transfer yields exactly one
// output transfer on the m_axis side: a start reports the effective length,
// a step while busy names one copy (tuser 1, tlast on the final copy), and a
// step while idle returns an all-zero result with tuser 0.
// The result is offered once the item has passed through the input register
// and the step logic has fed the result register. Throughput is one item per
// cycle while the receiver does not stall, as the state register is updated
// once per item.
// Reset clears the valid flags of both registers, the pointers and the
// remaining count, and leaves the block idle. When the receiver stalls, the
// result register holds, the input register takes one more item, and tready
// then drops until the result is taken.
// ----------------------------------------------------------------------------
module block_transfer_address_sequencer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata: mode, source_start, destination_start, length_start, zero padding
  input  logic [bta_pkg::InTdataW-1:0]   s_axis_tdata,
  // tuser: action
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata: source_address, destination_address, reported_length
  output logic [bta_pkg::OutTdataW-1:0]  m_axis_tdata,
  // tuser: copy_valid
  output logic                           m_axis_tuser,
  output logic                           m_axis_tlast
);

  localparam int unsigned A = bta_pkg::AddrW;

  bta_pkg::item_t      item_q;
  logic                in_valid_q;
  bta_pkg::result_t    res_q;
  bta_pkg::result_t    res_d;
  logic                out_valid_q;
  bta_pkg::seq_state_t state_q;
  bta_pkg::seq_state_t state_d;
  logic                advance;
  logic                in_xfer;

  // The held item moves on when the result register is free or being emptied.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q.action            <= bta_pkg::action_e'(s_axis_tuser);
      item_q.mode              <= bta_pkg::mode_e'(s_axis_tdata[0]);
      item_q.source_start      <= s_axis_tdata[A:1];
      item_q.destination_start <= s_axis_tdata[2*A:A+1];
      item_q.length_start      <= s_axis_tdata[2*A+bta_pkg::LenW:2*A+1];
    end
  end

  // Result and next state for the held item.
  bta_step_logic u_step (
    .item_i   (item_q),
    .state_i  (state_q),
    .result_o (res_d),
    .state_o  (state_d)
  );

  // Sequencer state, updated once per item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.source_pointer      <= '0;
      state_q.destination_pointer <= '0;
      state_q.remaining           <= '0;
      state_q.alternate_up        <= 1'b1;
      state_q.mode_in_use         <= bta_pkg::MODE_ALT_SRC;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {res_q.reported_length, res_q.destination_address,
                          res_q.source_address};
  assign m_axis_tuser  = res_q.copy_valid;
  assign m_axis_tlast  = res_q.last;

endmodule

### sv/bta_checker.sv
// ----------------------------------------------------------------------------
// Block transfer sequencer checker
// Port-level assertions for the block transfer address sequencer.
// ----------------------------------------------------------------------------
module bta_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [bta_pkg::OutTdataW-1:0] m_axis_tdata,
  input logic                          m_axis_tuser,
  input logic                          m_axis_tlast
);

  localparam int unsigned A = bta_pkg::AddrW;

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output transfer withdrawn while stalled");

  // Only a copy can be the final copy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
    else $error("last flagged on a result without a copy");

  // A copy result never reports a total length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[2*A+bta_pkg::LenW-1:2*A] == '0)
    else $error("copy result carries a total length");

  // A result without a copy carries no addresses.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[2*A-1:0] == '0)
    else $error("addresses present on a result without a copy");

endmodule

bind block_transfer_address_sequencer bta_checker u_bta_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
